[rtl/core/assert_macros.svh]
// assertion helpers for the rtl files, included by the decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/msa_rld_pkg.sv]
// ----------------------------------------------------------------------------
// msa_rld_pkg
// Types, codes and constants of the disk image run-length decoder.
// ----------------------------------------------------------------------------
package msa_rld_pkg;

  localparam int unsigned MAX_SECTORS_DEF  = 30;
  localparam int unsigned SECTOR_BYTES_DEF = 512;

  // wide enough for the largest sectors-per-track setting
  localparam int unsigned SPT_W = 6;

  localparam logic [7:0] MAGIC_HI = 8'h0E;
  localparam logic [7:0] MAGIC_LO = 8'h0F;
  localparam logic [7:0] RLE_MARK = 8'hE5;
  localparam logic [3:0] HDR_LAST = 4'd9;

  // result status codes
  localparam logic [2:0] ST_RUN       = 3'd0;
  localparam logic [2:0] ST_FINAL     = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_BAD_TRACK = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_LEN_HI    = 4'd1,
    PH_LEN_LO    = 4'd2,
    PH_LITERAL   = 4'd3,
    PH_RLE_BYTE  = 4'd4,
    PH_RLE_VAL   = 4'd5,
    PH_RLE_CNT_HI = 4'd6,
    PH_RLE_CNT_LO = 4'd7,
    PH_SKIP      = 4'd8,
    PH_DONE      = 4'd9,
    PH_ERROR     = 4'd10
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  run_byte;
    logic [15:0] run_length;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    phase_t           phase;
    logic [3:0]       header_index;
    logic [SPT_W-1:0] sectors_per_track;
    logic [1:0]       side_count;
    logic [15:0]      first_track;
    logic [15:0]      final_track;
    logic [15:0]      track_now;
    logic             side_now;
    logic [15:0]      track_length;
    logic [15:0]      bytes_left;
    logic [16:0]      bytes_made;
    logic [7:0]       held_value;
    logic [7:0]       held_count_high;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:             PH_HEADER,
    header_index:      '0,
    sectors_per_track: '0,
    side_count:        '0,
    first_track:       '0,
    final_track:       '0,
    track_now:         '0,
    side_now:          1'b0,
    track_length:      '0,
    bytes_left:        '0,
    bytes_made:        '0,
    held_value:        '0,
    held_count_high:   '0
  };

endpackage

[rtl/core/msa_rld_decode.sv]
// ----------------------------------------------------------------------------
// msa_rld_decode
// Next-state and result logic for one image byte.
// ----------------------------------------------------------------------------
module msa_rld_decode #(
  parameter int unsigned MAX_SECTORS  = msa_rld_pkg::MAX_SECTORS_DEF,
  parameter int unsigned SECTOR_BYTES = msa_rld_pkg::SECTOR_BYTES_DEF
) (
  input  msa_rld_pkg::state_t    st_i,
  input  msa_rld_pkg::in_item_t  item_i,
  output msa_rld_pkg::state_t    st_o,
  output logic                   have_o,
  output msa_rld_pkg::out_item_t res_o
);
  import msa_rld_pkg::*;

  state_t      s;
  logic [7:0]  b;
  logic        have;
  logic [7:0]  rb;
  logic [15:0] rl;
  logic [2:0]  stat;
  logic        bad;
  logic        check;
  logic        fill;
  logic [15:0] left_dec;
  logic [15:0] count;
  logic [16:0] made_new;
  logic [15:0] final_full;
  logic [1:0]  side_inc;
  logic        side_wrap;
  logic        image_end;

  assign b          = item_i.data_byte;
  assign left_dec   = st_i.bytes_left - 16'd1;
  assign count      = {st_i.held_count_high, b};
  assign made_new   = st_i.bytes_made +
                      {1'b0, (st_i.phase == PH_RLE_BYTE) ? 16'd1 : count};
  assign final_full = {st_i.final_track[15:8], b};
  assign side_inc   = {1'b0, st_i.side_now} + 2'd1;
  assign side_wrap  = (side_inc >= st_i.side_count);
  assign image_end  = (st_i.track_now == st_i.final_track) && (side_inc == st_i.side_count);

  always_comb begin
    s     = st_i;
    have  = 1'b0;
    rb    = '0;
    rl    = '0;
    stat  = ST_RUN;
    bad   = 1'b0;
    check = 1'b0;
    fill  = 1'b0;

    unique case (st_i.phase)
      PH_HEADER: begin
        case (st_i.header_index)
          4'd0: bad = (b != MAGIC_HI);
          4'd1: bad = (b != MAGIC_LO);
          4'd2: bad = (b != 8'd0);
          4'd3: begin
            bad = (b == 8'd0) || (b > 8'(MAX_SECTORS));
            s.sectors_per_track = b[SPT_W-1:0];
          end
          4'd4: bad = (b != 8'd0);
          4'd5: begin
            bad = (b > 8'd1);
            s.side_count = b[1:0] + 2'd1;
          end
          4'd6: s.first_track = {b, 8'd0};
          4'd7: s.first_track = {st_i.first_track[15:8], b};
          4'd8: s.final_track = {b, 8'd0};
          default: begin
            s.final_track  = final_full;
            bad            = (final_full < st_i.first_track);
            s.track_length = 16'(st_i.sectors_per_track * SECTOR_BYTES);
            s.track_now    = st_i.first_track;
            s.side_now     = 1'b0;
          end
        endcase
        if (bad) begin
          s.phase = PH_ERROR;
          have    = 1'b1;
          stat    = ST_BAD_HDR;
        end else if (st_i.header_index >= HDR_LAST) begin
          s.phase = PH_LEN_HI;
        end else begin
          s.header_index = st_i.header_index + 4'd1;
        end
      end
      PH_LEN_HI: begin
        s.held_count_high = b;
        s.phase           = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        s.bytes_left = count;
        s.bytes_made = '0;
        if (count == st_i.track_length) begin
          s.phase = PH_LITERAL;
        end else if (count == 16'd0) begin
          s.phase = PH_ERROR;
          have    = 1'b1;
          stat    = ST_BAD_TRACK;
        end else begin
          s.phase = PH_RLE_BYTE;
        end
      end
      PH_LITERAL: begin
        s.bytes_left = left_dec;
        have         = 1'b1;
        rb           = b;
        rl           = 16'd1;
        fill         = (left_dec == 16'd0);
      end
      PH_RLE_BYTE: begin
        s.bytes_left = left_dec;
        // a marker too close to the track end is taken as a literal
        if (b == RLE_MARK && left_dec >= 16'd3) begin
          s.phase = PH_RLE_VAL;
        end else begin
          have  = 1'b1;
          rb    = b;
          rl    = 16'd1;
          check = 1'b1;
        end
      end
      PH_RLE_VAL: begin
        s.bytes_left = left_dec;
        s.held_value = b;
        s.phase      = PH_RLE_CNT_HI;
      end
      PH_RLE_CNT_HI: begin
        s.bytes_left      = left_dec;
        s.held_count_high = b;
        s.phase           = PH_RLE_CNT_LO;
      end
      PH_RLE_CNT_LO: begin
        s.bytes_left = left_dec;
        have         = 1'b1;
        rb           = st_i.held_value;
        rl           = count;
        check        = 1'b1;
      end
      PH_SKIP: begin
        s.bytes_left = left_dec;
        if (left_dec == 16'd0) begin
          s.phase = PH_LEN_HI;
        end
      end
      default: begin
      end
    endcase

    // coded track bookkeeping after a run
    if (check) begin
      s.bytes_made = made_new;
      if (made_new > {1'b0, st_i.track_length}) begin
        s.phase = PH_ERROR;
        stat    = ST_BAD_TRACK;
      end else if (made_new == {1'b0, st_i.track_length}) begin
        fill = 1'b1;
      end else if (left_dec == 16'd0) begin
        s.phase = PH_ERROR;
        stat    = ST_BAD_TRACK;
      end else begin
        s.phase = PH_RLE_BYTE;
      end
    end

    // track full: finish the image or step to the next side or track
    if (fill) begin
      if (image_end) begin
        s.phase = PH_DONE;
        stat    = ST_FINAL;
      end else begin
        s.side_now   = side_wrap ? 1'b0 : side_inc[0];
        s.track_now  = side_wrap ? st_i.track_now + 16'd1 : st_i.track_now;
        s.bytes_made = '0;
        s.phase      = (s.bytes_left != 16'd0) ? PH_SKIP : PH_LEN_HI;
      end
    end

    if (stat == ST_BAD_HDR || stat == ST_BAD_TRACK) begin
      rb = '0;
      rl = '0;
    end

    if (item_i.end_of_file) begin
      if (!(have && stat != ST_RUN) && s.phase != PH_DONE && s.phase != PH_ERROR) begin
        have = 1'b1;
        stat = ST_TRUNC;
      end
      s = STATE_RESET;
    end
  end

  assign st_o             = s;
  assign have_o           = have;
  assign res_o.run_byte   = rb;
  assign res_o.run_length = rl;
  assign res_o.status     = stat;

endmodule

[rtl/core/msa_image_run_length_decoder_core.sv]
// The decoder takes one byte of a compressed floppy disk image per cycle and
// gives at most one run (value, count) per byte: the byte is held in the input
// register and its run is written to the result register. It sustains one
// byte every cycle while the result register can take a new run, and keeps
// taking bytes while a result waits in the output register as long as the
// byte in hand produces no result. Status reports bad headers, bad tracks,
// truncation and the run that completes the image; a byte marked end of file
// returns the decoder to its reset state. There is no start-up clearing pass.
// ----------------------------------------------------------------------------
// msa_image_run_length_decoder_core
// Top level: input register, decode logic, state and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msa_image_run_length_decoder_core #(
  parameter int unsigned MAX_SECTORS  = msa_rld_pkg::MAX_SECTORS_DEF,
  parameter int unsigned SECTOR_BYTES = msa_rld_pkg::SECTOR_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  msa_rld_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output msa_rld_pkg::out_item_t out_data
);
  import msa_rld_pkg::*;

  in_item_t  in_r;
  logic      in_valid_r;
  state_t    state_r;
  state_t    state_nxt;
  logic      have;
  out_item_t res;
  out_item_t out_r;
  logic      out_valid_r;
  logic      advance;

  msa_rld_decode #(
    .MAX_SECTORS  (MAX_SECTORS),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_decode (
    .st_i   (state_r),
    .item_i (in_r),
    .st_o   (state_nxt),
    .have_o (have),
    .res_o  (res)
  );

  // a byte moves on unless its result would land on an unread one
  assign advance  = in_valid_r && (!have || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance && have) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance && have) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid_r, in_ready, "input stalled with empty output")
  `ASSERT_IMPLY(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready, !(advance && have), "pending result overwritten")
  `ASSERT_NEXT(a_eof_rearm, clk, rst_n, advance && in_r.end_of_file, state_r.phase == PH_HEADER && state_r.header_index == 4'd0, "no rearm after end of file")
  `ASSERT_IMPLY(a_made_in_range, clk, rst_n, state_r.phase == PH_RLE_BYTE, state_r.bytes_made < {1'b0, state_r.track_length}, "track count out of range")

endmodule
